FILE: src/sha1_message_digest_unit_defines.svh
// assertion macros for the sha-1 digest unit
// no dependencies; included by the modules that carry assertions
`ifndef SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define SMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SMD_ASSERT_NOW(lbl, ante, cons, msg)
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/smd_pkg.sv
// shared types, constants and round functions for the sha-1 digest unit
// no dependencies
`timescale 1ns / 1ps

package smd_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int FILL_W      = $clog2(BLOCK_BYTES);
  localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
  localparam int COUNT_W     = 61;
  localparam int ROUND_W     = 7;

  localparam logic [FILL_W-1:0]  FILL_LAST = FILL_W'(BLOCK_BYTES - 1);
  localparam logic [FILL_W-1:0]  LEN_START = FILL_W'(BLOCK_BYTES - 8);
  localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

  localparam logic [31:0] INIT_H0 = 32'h67452301;
  localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
  localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
  localparam logic [31:0] INIT_H3 = 32'h10325476;
  localparam logic [31:0] INIT_H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_COMP,
    S_UPD,
    S_OUT
  } smd_state_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } smd_byte_sel_t;

  typedef struct packed {
    logic          push;
    smd_byte_sel_t sel;
    logic          count_inc;
    logic          load_work;
    logic          round_en;
    logic          update_chain;
    logic          restart;
  } smd_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              round_last;
  } smd_status_t;

  // boolean function of the round group
  function automatic logic [31:0] round_f(input logic [ROUND_W-1:0] t,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    priority if (t < 7'd20) begin
      f = d ^ (b & (c ^ d));
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // additive constant of the round group
  function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] t);
    logic [31:0] k;
    priority if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

FILE: src/smd_datapath.sv
// datapath: block shift line, message schedule, round logic, chaining words
// depends on smd_pkg
`timescale 1ns / 1ps

module smd_datapath import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  smd_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  output smd_status_t st,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);

  // block line: word 0 sits in the top 32 bits
  logic [BLOCK_BITS-1:0] blk;
  logic [FILL_W-1:0]     fill;
  logic [COUNT_W-1:0]    count;
  logic [ROUND_W-1:0]    round;
  logic [31:0]           a, b, c, d, e;
  logic [31:0]           h0, h1, h2, h3, h4;

  logic [63:0]  len_bits;
  logic [7:0]   len_byte;
  logic [7:0]   push_byte;
  logic [31:0]  w_cur;
  logic [31:0]  w_mix;
  logic [31:0]  w_new;
  logic [31:0]  tmp;

  // length byte for the current position, most significant first
  assign len_bits = {count, 3'b000};
  assign len_byte = len_bits[{~fill[2:0], 3'b000} +: 8];

  // byte source for the block line
  always_comb begin
    unique case (cmd.sel)
      SEL_DATA: push_byte = data_byte;
      SEL_PAD:  push_byte = PAD_BYTE;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_byte;
      default:  push_byte = 8'h00;
    endcase
  end

  // schedule word for this round and the one sixteen rounds ahead
  assign w_cur = blk[BLOCK_BITS-1 -: 32];
  assign w_mix = blk[BLOCK_BITS-1-32*13 -: 32] ^ blk[BLOCK_BITS-1-32*8 -: 32]
               ^ blk[BLOCK_BITS-1-32*2 -: 32] ^ w_cur;
  assign w_new = {w_mix[30:0], w_mix[31]};

  // round sum
  assign tmp = {a[26:0], a[31:27]} + round_f(round, b, c, d) + e + round_k(round) + w_cur;

  // control registers: fill, length, round, chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
      round <= '0;
      h0    <= INIT_H0;
      h1    <= INIT_H1;
      h2    <= INIT_H2;
      h3    <= INIT_H3;
      h4    <= INIT_H4;
    end else begin
      if (cmd.push) begin
        fill <= fill + 1'b1;
      end
      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
      if (cmd.load_work) begin
        round <= '0;
      end else if (cmd.round_en) begin
        round <= round + 1'b1;
      end
      if (cmd.update_chain) begin
        h0 <= h0 + a;
        h1 <= h1 + b;
        h2 <= h2 + c;
        h3 <= h3 + d;
        h4 <= h4 + e;
      end
      if (cmd.restart) begin
        fill  <= '0;
        count <= '0;
        h0    <= INIT_H0;
        h1    <= INIT_H1;
        h2    <= INIT_H2;
        h3    <= INIT_H3;
        h4    <= INIT_H4;
      end
    end
  end

  // block line and working variables
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[BLOCK_BITS-9:0], push_byte};
    end else if (cmd.round_en) begin
      blk <= {blk[BLOCK_BITS-33:0], w_new};
    end
    if (cmd.load_work) begin
      a <= h0;
      b <= h1;
      c <= h2;
      d <= h3;
      e <= h4;
    end else if (cmd.round_en) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  assign st.fill       = fill;
  assign st.round_last = (round == ROUND_LAST);

  assign digest_word0 = h0;
  assign digest_word1 = h1;
  assign digest_word2 = h2;
  assign digest_word3 = h3;
  assign digest_word4 = h4;

endmodule

FILE: src/smd_ctrl.sv
// controller: request handshake, padding sequence and compression rounds
// depends on smd_pkg and sha1_message_digest_unit_defines.svh
`timescale 1ns / 1ps
`include "sha1_message_digest_unit_defines.svh"

module smd_ctrl import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  output logic        out_valid,
  input  logic        out_stall,
  input  smd_status_t st,
  output smd_cmd_t    cmd
);

  smd_state_t state, state_next;
  smd_state_t ret, ret_next;
  logic       fill_last;

  assign fill_last = (st.fill == FILL_LAST);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next       = state;
    ret_next         = ret;
    cmd              = '0;
    cmd.sel          = SEL_DATA;
    in_stall         = 1'b1;
    out_valid        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (op == OP_ABSORB) begin
            cmd.push      = 1'b1;
            cmd.count_inc = 1'b1;
            if (fill_last) begin
              cmd.load_work = 1'b1;
              ret_next      = S_IDLE;
              state_next    = S_COMP;
            end
          end else begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_PAD;
        if (fill_last) begin
          cmd.load_work = 1'b1;
          ret_next      = S_PADZ;
          state_next    = S_COMP;
        end else begin
          state_next = S_PADZ;
        end
      end
      S_PADZ: begin
        if (st.fill == LEN_START) begin
          state_next = S_PADLEN;
        end else begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_ZERO;
          // short tail: block fills before the length fits
          if (fill_last) begin
            cmd.load_work = 1'b1;
            ret_next      = S_PADZ;
            state_next    = S_COMP;
          end
        end
      end
      S_PADLEN: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_LEN;
        if (fill_last) begin
          cmd.load_work = 1'b1;
          ret_next      = S_OUT;
          state_next    = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round_en = 1'b1;
        if (st.round_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update_chain = 1'b1;
        state_next       = ret;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.restart = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SMD_ASSERT_NEXT(a_rounds_end, (state == S_COMP) && st.round_last, state == S_UPD, "last round must be followed by the chain update")
  `SMD_ASSERT_NEXT(a_block_full, (state != S_COMP) && (state_next == S_COMP), st.fill == '0, "compression must start on a full block")
  `SMD_ASSERT_NOW(a_len_slot, state == S_PADLEN, st.fill[FILL_W-1:3] == LEN_START[FILL_W-1:3], "length bytes must land in the last eight slots")
  `SMD_ASSERT_NOW(a_out_after_upd, $rose(out_valid), $past(state) == S_UPD, "digest must follow a chain update")

endmodule

FILE: src/sha1_message_digest_unit.sv
// An absorb request shifts its byte into the block line; a byte that fills the block
// starts 80 rounds at one per cycle in the datapath, then the chain update, and further
// requests stall meanwhile. Finish: padding goes in one byte per cycle, held while a
// full block is compressed, then the digest shows; the length spills into an extra
// block when it does not fit in the current one.
// Synchronous reset loads the standard initial chaining words and clears the length.
// top level of the sha-1 digest unit
// depends on smd_pkg, smd_ctrl and smd_datapath
`timescale 1ns / 1ps

module sha1_message_digest_unit import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);

  smd_cmd_t    cmd;
  smd_status_t st;

  // sequencer
  smd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // block line, rounds and chaining words
  smd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .st           (st),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

endmodule
